### design/rlwq_pkg.sv
// Shared types, sizes and status codes for the recursive lock with wait queue.
`timescale 1ns / 1ps

package rlwq_pkg;

   // Sizing
   localparam int THREAD_COUNT = 256;
   localparam int QUEUE_DEPTH  = 16;

   localparam int TID_W   = 8;
   localparam int NEST_W  = 8;
   localparam int MAP_DEPTH = (THREAD_COUNT < (1 << TID_W)) ? THREAD_COUNT : (1 << TID_W);
   localparam int MAP_W   = $clog2(MAP_DEPTH);
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int USED_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [NEST_W-1:0] NEST_MAX = {NEST_W{1'b1}};
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [USED_W-1:0] USED_FULL = USED_W'(QUEUE_DEPTH);

   // Request kinds
   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_QUEUED     = 3'd1,
      ST_NOT_HOLDER = 3'd2,
      ST_DUP_WAIT   = 3'd3,
      ST_FULL       = 3'd4,
      ST_NEST_OVF   = 3'd5
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [TID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic             wake_valid;
      logic [TID_W-1:0] wake_thread;
      logic             lock_free;
   } rsp_type;

   // Queue state seen by the lock controller
   typedef struct packed {
      logic [TID_W-1:0] head_tid;
      logic             empty;
      logic             full;
      logic             tid_waiting;
   } qstat_type;

   // Queue updates issued by the lock controller
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [TID_W-1:0] tid;
   } qcmd_type;

endpackage

### design/rlwq_wait_queue.sv
// Waiter FIFO with per-thread waiting bitmap.
`timescale 1ns / 1ps

module rlwq_wait_queue
   import rlwq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qcmd_type   cmd,
   output qstat_type  stat
);

   logic [TID_W-1:0]     fifo_mem [QUEUE_DEPTH];
   logic [TID_W-1:0]     head_tid_ff;
   logic [QPTR_W-1:0]    head_ff, head_in;
   logic [QPTR_W-1:0]    tail_ff, tail_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic [MAP_DEPTH-1:0] map_ff, map_in;
   logic [MAP_W-1:0]     tid_idx;
   logic [MAP_W-1:0]     head_idx;

   assign tid_idx  = cmd.tid[MAP_W-1:0];
   assign head_idx = head_tid_ff[MAP_W-1:0];

   // Status toward the controller
   always_comb begin
      stat.head_tid    = head_tid_ff;
      stat.empty       = (used_ff == '0);
      stat.full        = (used_ff == USED_FULL);
      stat.tid_waiting = map_ff[tid_idx];
   end

   // Pointer and bitmap update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      map_in  = map_ff;
      if (cmd.push) begin
         tail_in         = (tail_ff == QPTR_LAST) ? '0 : tail_ff + 1'b1;
         used_in         = used_ff + 1'b1;
         map_in[tid_idx] = 1'b1;
      end else if (cmd.pop) begin
         head_in          = (head_ff == QPTR_LAST) ? '0 : head_ff + 1'b1;
         used_in          = used_ff - 1'b1;
         map_in[head_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         used_ff <= '0;
         map_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         used_ff <= used_in;
         map_ff  <= map_in;
      end
   end

   // Storage, no reset; head entry read into a register,
   // a push into an empty queue goes straight to the head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         fifo_mem[tail_ff] <= cmd.tid;
      end
      if (cmd.push && tail_ff == head_in) begin
         head_tid_ff <= cmd.tid;
      end else begin
         head_tid_ff <= fifo_mem[head_in];
      end
   end

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_FULL)
      else $error("waiter count above queue depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (used_ff == '0 || used_ff == USED_FULL) |-> head_ff == tail_ff)
      else $error("pointers disagree with waiter count");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && stat.full) && !(cmd.pop && stat.empty))
      else $error("queue pushed when full or popped when empty");

   a_push_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> map_ff[$past(tid_idx)])
      else $error("queued thread not marked waiting");

endmodule

### design/rlwq_lock_ctrl.sv
// Lock ownership state and per-item decision logic.
`timescale 1ns / 1ps

module rlwq_lock_ctrl
   import rlwq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  req_type    item,
   input  qstat_type  qstat,
   output qcmd_type   qcmd,
   output rsp_type    rsp
);

   logic [TID_W-1:0]  owner_ff, owner_in;
   logic              owned_ff, owned_in;
   logic [NEST_W-1:0] nest_ff, nest_in;
   logic              in_range;
   logic              is_holder;

   assign in_range  = (int'(item.thread_id) < THREAD_COUNT);
   assign is_holder = owned_ff && (owner_ff == item.thread_id);

   // Decide the item's outcome and the next lock state
   always_comb begin
      owner_in         = owner_ff;
      owned_in         = owned_ff;
      nest_in          = nest_ff;
      qcmd.push        = 1'b0;
      qcmd.pop         = 1'b0;
      qcmd.tid         = item.thread_id;
      rsp.status       = ST_OK;
      rsp.wake_valid   = 1'b0;
      rsp.wake_thread  = '0;
      priority if (!in_range) begin
         rsp.status = ST_NOT_HOLDER;
      end else if (item.kind == KIND_ACQUIRE) begin
         priority if (!owned_ff) begin
            owned_in = 1'b1;
            owner_in = item.thread_id;
            nest_in  = NEST_W'(1);
         end else if (is_holder) begin
            if (nest_ff == NEST_MAX) begin
               rsp.status = ST_NEST_OVF;
            end else begin
               nest_in = nest_ff + 1'b1;
            end
         end else if (qstat.tid_waiting) begin
            rsp.status = ST_DUP_WAIT;
         end else if (qstat.full) begin
            rsp.status = ST_FULL;
         end else begin
            qcmd.push  = fire;
            rsp.status = ST_QUEUED;
         end
      end else begin
         priority if (!is_holder) begin
            rsp.status = ST_NOT_HOLDER;
         end else if (nest_ff > NEST_W'(1)) begin
            nest_in = nest_ff - 1'b1;
         end else if (!qstat.empty) begin
            // hand off to the head waiter
            qcmd.pop        = fire;
            owner_in        = qstat.head_tid;
            nest_in         = NEST_W'(1);
            rsp.wake_valid  = 1'b1;
            rsp.wake_thread = qstat.head_tid;
         end else begin
            owned_in = 1'b0;
            owner_in = '0;
            nest_in  = '0;
         end
      end
      rsp.lock_free = !owned_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= '0;
         owned_ff <= 1'b0;
         nest_ff  <= '0;
      end else if (fire) begin
         owner_ff <= owner_in;
         owned_ff <= owned_in;
         nest_ff  <= nest_in;
      end
   end

   // Checks
   a_held_nested: assert property (@(posedge clock) disable iff (reset)
      owned_ff |-> nest_ff != '0)
      else $error("held lock with zero nesting");

   a_free_clear: assert property (@(posedge clock) disable iff (reset)
      !owned_ff |-> (owner_ff == '0 && nest_ff == '0))
      else $error("free lock keeps owner or count");

   a_wake_owner: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.wake_valid) |=> (owned_ff && owner_ff == $past(qstat.head_tid)))
      else $error("woken thread does not hold the lock");

endmodule

### design/recursive_lock_with_wait_queue.sv
// Top level: input register, lock decision, result register.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_data (kind, thread_id)
//   rsp_     out        rsp_valid / rsp_stall  rsp_data (status, wake, lock_free)
//
// One item per cycle sustained while the result side does not stall; the result of an item is
// registered in the result register as the item leaves the input register. Each item reads and
// updates the lock state between the input register and the result register, so the next item
// sees it at once. Reset is synchronous; it frees the lock, empties the queue and clears the
// waiting bitmap. A stalled result holds the pipeline; the input side stalls only while its
// register is full and cannot move on.
`timescale 1ns / 1ps

module recursive_lock_with_wait_queue
   import rlwq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      advance;
   logic      fire;
   rsp_type   rsp_next;
   qstat_type qstat;
   qcmd_type  qcmd;

   // Pipeline flow control
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   rlwq_lock_ctrl u_lock_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_data_ff),
      .qstat (qstat),
      .qcmd  (qcmd),
      .rsp   (rsp_next)
   );

   rlwq_wait_queue u_wait_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .stat  (qstat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/sv/recursive_lock_with_wait_queue_tb.sv
// Testbench for the recursive lock with wait queue: random requests, predicted results.
`timescale 1ns / 1ps

module recursive_lock_with_wait_queue_tb;
   import rlwq_pkg::*;

   // Lock predictor and store of expected results
   class lock_scoreboard;
      logic [TID_W-1:0]  holder;
      bit                held;
      logic [NEST_W-1:0] depth;
      logic [TID_W-1:0]  waiters[$];
      bit                queued_map[THREAD_COUNT];
      rsp_type           pending[$];
      int                errors;

      function new();
         holder = '0;
         held   = 1'b0;
         depth  = '0;
         errors = 0;
         foreach (queued_map[i]) queued_map[i] = 1'b0;
      endfunction

      // Work out the result of an accepted request and update the lock state
      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         e.status = ST_OK;
         if (int'(r.thread_id) >= THREAD_COUNT) begin
            e.status = ST_NOT_HOLDER;
         end else if (r.kind == KIND_ACQUIRE) begin
            if (!held) begin
               held   = 1'b1;
               holder = r.thread_id;
               depth  = NEST_W'(1);
            end else if (holder == r.thread_id) begin
               if (depth == NEST_MAX) e.status = ST_NEST_OVF;
               else depth = depth + 1'b1;
            end else if (queued_map[r.thread_id]) begin
               e.status = ST_DUP_WAIT;
            end else if (waiters.size() >= QUEUE_DEPTH) begin
               e.status = ST_FULL;
            end else begin
               waiters.push_back(r.thread_id);
               queued_map[r.thread_id] = 1'b1;
               e.status = ST_QUEUED;
            end
         end else begin
            if (!held || holder != r.thread_id) begin
               e.status = ST_NOT_HOLDER;
            end else if (depth > 1) begin
               depth = depth - 1'b1;
            end else if (waiters.size() > 0) begin
               // final release hands the lock to the head waiter
               holder = waiters.pop_front();
               queued_map[holder] = 1'b0;
               depth = NEST_W'(1);
               e.wake_valid  = 1'b1;
               e.wake_thread = holder;
            end else begin
               held   = 1'b0;
               holder = '0;
               depth  = '0;
            end
         end
         e.lock_free = !held;
         pending.push_back(e);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Compare a result with the oldest expectation
      task check_response(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d wake=%0b/%0d free=%0b",
                                      r.status, r.wake_valid, r.wake_thread, r.lock_free));
            return;
         end
         e = pending.pop_front();
         if (r.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", r.status, e.status));
         if (r.wake_valid !== e.wake_valid)
            report_mismatch($sformatf("wake_valid %0b, expected %0b",
                                      r.wake_valid, e.wake_valid));
         if (r.wake_thread !== e.wake_thread)
            report_mismatch($sformatf("wake_thread %0d, expected %0d",
                                      r.wake_thread, e.wake_thread));
         if (r.lock_free !== e.lock_free)
            report_mismatch($sformatf("lock_free %0b, expected %0b",
                                      r.lock_free, e.lock_free));
      endtask
   endclass

   localparam int ITEM_TARGET = 1850;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   lock_scoreboard sb = new();
   int  items_sent = 0;
   int  results_seen = 0;
   bit  no_gaps = 1'b0;
   bit  hold_done = 1'b0;

   recursive_lock_with_wait_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("recursive_lock_with_wait_queue_tb: errors");
      $finish;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
         results_seen <= results_seen + 1;
      end
   end

   // Result-side stalls: mostly short, some long free runs, one long hold-off
   initial begin : rsp_stall_gen
      int free_run;
      int stall_run;
      @(posedge clock);
      forever begin
         free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
         repeat (free_run) @(posedge clock);
         if (!hold_done && results_seen >= 200) begin
            hold_done = 1'b1;
            stall_run = 300;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: stall_run = 0;
               9:          stall_run = $urandom_range(10, 40);
               default:    stall_run = $urandom_range(1, 3);
            endcase
         end
         if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_run) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request, wait until it is taken, then maybe idle
   task automatic send_item(logic kind, logic [TID_W-1:0] tid);
      req_type r;
      int gap;
      r.kind      = kind;
      r.thread_id = tid;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Release until the lock is free, waking every waiter in turn
   task automatic drain_lock();
      while (sb.held) send_item(KIND_RELEASE, sb.holder);
   endtask

   // A few threads fight over the lock, nesting and handing it on
   task automatic contend();
      logic [TID_W-1:0] pool[6];
      int               n;
      logic [TID_W-1:0] t;
      logic             k;
      foreach (pool[i]) pool[i] = TID_W'($urandom);
      n = $urandom_range(2, 6);
      repeat ($urandom_range(10, 40)) begin
         t = pool[$urandom_range(0, n - 1)];
         if (sb.held && t == sb.holder)
            k = ($urandom_range(0, 2) == 0) ? KIND_ACQUIRE : KIND_RELEASE;
         else
            k = ($urandom_range(0, 5) == 0) ? KIND_RELEASE : KIND_ACQUIRE;
         send_item(k, t);
      end
      drain_lock();
   endtask

   // Fill the wait queue to the brim, push past it, then drain
   task automatic fill_queue();
      send_item(KIND_ACQUIRE, TID_W'($urandom));
      while (sb.waiters.size() < QUEUE_DEPTH) begin
         send_item(KIND_ACQUIRE, TID_W'($urandom));
         if ($urandom_range(0, 7) == 0 && sb.waiters.size() > 0)
            send_item(KIND_ACQUIRE, sb.waiters[$urandom_range(0, sb.waiters.size() - 1)]);
      end
      repeat ($urandom_range(1, 4)) send_item(KIND_ACQUIRE, TID_W'($urandom));
      drain_lock();
   endtask

   // Nest the holder past the counter limit, with stray requests mixed in
   task automatic deep_nest();
      logic [TID_W-1:0] t;
      t = TID_W'($urandom);
      send_item(KIND_ACQUIRE, t);
      repeat (258) begin
         send_item(KIND_ACQUIRE, t);
         if ($urandom_range(0, 15) == 0)
            send_item(logic'($urandom_range(0, 1)), TID_W'($urandom));
      end
      drain_lock();
   endtask

   // Unstructured requests over the whole id range
   task automatic noise();
      repeat ($urandom_range(5, 20))
         send_item(logic'($urandom_range(0, 1)), TID_W'($urandom));
      drain_lock();
   endtask

   // Main sequence
   initial begin
      int r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: grant, nesting, queueing, duplicate, non-holder, handoffs
      no_gaps = 1'b1;
      send_item(KIND_RELEASE, 8'h00);
      send_item(KIND_ACQUIRE, 8'h00);
      send_item(KIND_ACQUIRE, 8'h00);
      send_item(KIND_ACQUIRE, 8'hFF);
      send_item(KIND_ACQUIRE, 8'hFF);
      send_item(KIND_RELEASE, 8'hFF);
      send_item(KIND_ACQUIRE, 8'hAA);
      send_item(KIND_ACQUIRE, 8'h55);
      send_item(KIND_RELEASE, 8'h00);
      send_item(KIND_RELEASE, 8'h00);
      send_item(KIND_ACQUIRE, 8'hFF);
      send_item(KIND_RELEASE, 8'hFF);
      send_item(KIND_RELEASE, 8'hFF);
      send_item(KIND_RELEASE, 8'hAA);
      send_item(KIND_RELEASE, 8'h55);
      send_item(KIND_RELEASE, 8'h55);
      send_item(KIND_ACQUIRE, 8'h55);
      send_item(KIND_RELEASE, 8'h55);
      no_gaps = 1'b0;

      // Random: limit cases first, then a mix of episodes
      deep_nest();
      fill_queue();
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 55) contend();
         else if (r < 70) fill_queue();
         else noise();
      end
      req_valid <= 1'b0;

      // Drain
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("recursive_lock_with_wait_queue_tb: clean");
      else
         $display("recursive_lock_with_wait_queue_tb: errors");
      $finish;
   end

endmodule
